[rtl/chd_pkg.sv]
// Package with the types, constants and codes shared by the handover decider modules.
package chd_pkg;

   localparam int CELL_ID_BITS   = 8;
   localparam int LEVEL_BITS     = 16;
   localparam int MIN_LEVEL_BITS = 16;
   localparam int DIVISOR_BITS   = 8;
   localparam int TICK_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int EVENT_BITS     = 4;
   localparam int CMP_BITS       =
      ((LEVEL_BITS > MIN_LEVEL_BITS) ? LEVEL_BITS : MIN_LEVEL_BITS) + 1;
   localparam int DIV_COUNT_BITS = $clog2(LEVEL_BITS);

   localparam int LEVEL_MIN_INT  = -(1 <<< (LEVEL_BITS - 1));
   localparam int VERY_BAD_INT   = (-15984 < LEVEL_MIN_INT) ? LEVEL_MIN_INT : -15984;

   typedef logic [CELL_ID_BITS-1:0]  cell_id_type;
   typedef logic [LEVEL_BITS-1:0]    level_type;
   typedef logic [TICK_BITS-1:0]     tick_count_type;
   typedef logic [DIVISOR_BITS-1:0]  divisor_type;
   typedef logic [CMP_BITS-1:0]      cmp_level_type;

   localparam level_type VERY_BAD_LEVEL = LEVEL_BITS'(VERY_BAD_INT);
   localparam logic [MIN_LEVEL_BITS-1:0] MIN_LEVEL_RESET = MIN_LEVEL_BITS'(-1600);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HANDOVER_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LEVEL         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HYSTERESIS_DIV    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_DELAY       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HANDOVER_LATENCY  = 3'd4;

   localparam logic REQ_MEASUREMENT = 1'b0;
   localparam logic REQ_TICK        = 1'b1;

   typedef enum logic [EVENT_BITS-1:0] {
      EV_NONE             = 4'd0,
      EV_DISABLED         = 4'd1,
      EV_WEAK             = 4'd2,
      EV_BUSY             = 4'd3,
      EV_SERVING_STRONGER = 4'd4,
      EV_SERVING_REFRESH  = 4'd5,
      EV_NEW_CANDIDATE    = 4'd6,
      EV_SERVING_LOST     = 4'd7,
      EV_STARTED          = 4'd8,
      EV_COMPLETED        = 4'd9
   } event_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic cmp_level_type ext_level(input level_type value);
      ext_level = {{(CMP_BITS - LEVEL_BITS){value[LEVEL_BITS-1]}}, value};
   endfunction

   function automatic cmp_level_type ext_min(input logic [MIN_LEVEL_BITS-1:0] value);
      ext_min = {{(CMP_BITS - MIN_LEVEL_BITS){value[MIN_LEVEL_BITS-1]}}, value};
   endfunction

endpackage

[rtl/chd_divider.sv]
// Iterative signed level by unsigned divisor division, one quotient bit per cycle.
module chd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  chd_pkg::level_type   dividend,
   input  chd_pkg::divisor_type divisor,
   output logic                 done,
   output chd_pkg::level_type   quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [chd_pkg::DIV_COUNT_BITS-1:0]  count_ff;
   chd_pkg::level_type                  quo_ff;
   chd_pkg::divisor_type                rem_ff;
   chd_pkg::divisor_type                divisor_ff;
   logic                                neg_ff;

   logic [chd_pkg::DIVISOR_BITS:0]      rem_shift;
   logic [chd_pkg::DIVISOR_BITS:0]      rem_diff;
   logic                                quo_bit;
   chd_pkg::divisor_type                rem_in;
   chd_pkg::level_type                  magnitude;

   assign magnitude = dividend[chd_pkg::LEVEL_BITS-1] ? (~dividend + 1'b1) : dividend;
   assign rem_shift = {rem_ff, quo_ff[chd_pkg::LEVEL_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign quo_bit   = (rem_shift >= {1'b0, divisor_ff});
   assign rem_in    = quo_bit ? rem_diff[chd_pkg::DIVISOR_BITS-1:0]
                              : rem_shift[chd_pkg::DIVISOR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
         if (count_ff == chd_pkg::DIV_COUNT_BITS'(chd_pkg::LEVEL_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= magnitude;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         neg_ff     <= dividend[chd_pkg::LEVEL_BITS-1];
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[chd_pkg::LEVEL_BITS-2:0], quo_bit};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = (divisor_ff == '0) ? '0 : (neg_ff ? (~quo_ff + 1'b1) : quo_ff);

endmodule

[rtl/chd_datapath.sv]
// Datapath with configuration, decision state, timers, threshold divider and result register.
module chd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  chd_pkg::cmd_type                      cmd,
   output chd_pkg::status_type                   status,
   input  logic                                  req_type,
   input  chd_pkg::cell_id_type                  req_source_cell,
   input  chd_pkg::level_type                    req_level,
   input  logic                                  csr_valid,
   input  logic [chd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [chd_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [chd_pkg::EVENT_BITS-1:0]        rsp_event_code,
   output chd_pkg::cell_id_type                  rsp_serving_cell,
   output chd_pkg::cell_id_type                  rsp_candidate_cell,
   output chd_pkg::level_type                    rsp_candidate_level,
   output logic                                  rsp_handover_busy
);

   logic                                enable_ff;
   logic [chd_pkg::MIN_LEVEL_BITS-1:0]  min_level_ff;
   chd_pkg::divisor_type                divisor_ff;
   chd_pkg::tick_count_type             start_delay_ff;
   chd_pkg::tick_count_type             latency_ff;

   logic                                type_ff;
   chd_pkg::cell_id_type                src_ff;
   chd_pkg::level_type                  level_ff;

   chd_pkg::cell_id_type                serving_ff, serving_in;
   chd_pkg::cell_id_type                cand_id_ff, cand_id_in;
   chd_pkg::level_type                  cand_lvl_ff, cand_lvl_in;
   chd_pkg::level_type                  thr_ff;
   logic                                start_armed_ff, start_armed_in;
   chd_pkg::tick_count_type             start_count_ff, start_count_in;
   logic                                finish_armed_ff, finish_armed_in;
   chd_pkg::tick_count_type             finish_count_ff, finish_count_in;
   chd_pkg::event_code_type             event_ff, event_in;
   logic                                thr_clear;
   logic                                div_needed;
   chd_pkg::level_type                  div_dividend;
   logic                                div_done;
   chd_pkg::level_type                  div_quotient;

   logic                                rsp_valid_ff;
   logic [chd_pkg::EVENT_BITS-1:0]      rsp_event_ff;
   chd_pkg::cell_id_type                rsp_serving_ff;
   chd_pkg::cell_id_type                rsp_cand_id_ff;
   chd_pkg::level_type                  rsp_cand_lvl_ff;
   logic                                rsp_busy_ff;

   chd_pkg::cmp_level_type              lvl_ext;
   chd_pkg::cmp_level_type              min_ext;
   chd_pkg::cmp_level_type              bar_ext;
   chd_pkg::tick_count_type             half_latency;

   assign lvl_ext      = chd_pkg::ext_level(level_ff);
   assign min_ext      = chd_pkg::ext_min(min_level_ff);
   assign bar_ext      = chd_pkg::ext_level(cand_lvl_ff) + chd_pkg::ext_level(thr_ff);
   assign half_latency = latency_ff >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         min_level_ff   <= chd_pkg::MIN_LEVEL_RESET;
         divisor_ff     <= '0;
         start_delay_ff <= chd_pkg::TICK_BITS'(1);
         latency_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            chd_pkg::CSR_HANDOVER_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            chd_pkg::CSR_MIN_LEVEL: begin
               min_level_ff <= csr_wdata[chd_pkg::MIN_LEVEL_BITS-1:0];
            end
            chd_pkg::CSR_HYSTERESIS_DIV: begin
               divisor_ff <= csr_wdata[chd_pkg::DIVISOR_BITS-1:0];
            end
            chd_pkg::CSR_START_DELAY: begin
               start_delay_ff <= csr_wdata[chd_pkg::TICK_BITS-1:0];
            end
            chd_pkg::CSR_HANDOVER_LATENCY: begin
               latency_ff <= csr_wdata[chd_pkg::TICK_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         src_ff   <= req_source_cell;
         level_ff <= req_level;
      end
   end

   always_comb begin
      event_in        = chd_pkg::EV_NONE;
      serving_in      = serving_ff;
      cand_id_in      = cand_id_ff;
      cand_lvl_in     = cand_lvl_ff;
      start_armed_in  = start_armed_ff;
      start_count_in  = start_count_ff;
      finish_armed_in = finish_armed_ff;
      finish_count_in = finish_count_ff;
      thr_clear       = 1'b0;
      div_needed      = 1'b0;
      div_dividend    = level_ff;
      if (type_ff == chd_pkg::REQ_TICK) begin
         div_dividend = cand_lvl_ff;
         if (finish_armed_ff) begin
            if (finish_count_ff > chd_pkg::TICK_BITS'(1)) begin
               finish_count_in = finish_count_ff - 1'b1;
            end else begin
               finish_armed_in = 1'b0;
               finish_count_in = '0;
               serving_in      = cand_id_ff;
               div_needed      = 1'b1;
               event_in        = chd_pkg::EV_COMPLETED;
            end
         end else if (start_armed_ff) begin
            if (start_count_ff > chd_pkg::TICK_BITS'(1)) begin
               start_count_in = start_count_ff - 1'b1;
            end else begin
               start_armed_in = 1'b0;
               start_count_in = '0;
               if (serving_ff != cand_id_ff) begin
                  finish_armed_in = 1'b1;
                  event_in        = chd_pkg::EV_STARTED;
                  if (serving_ff == '0) begin
                     finish_count_in = latency_ff - half_latency;
                  end else if (cand_id_ff == '0) begin
                     finish_count_in = half_latency;
                  end else begin
                     finish_count_in = latency_ff;
                  end
               end
            end
         end
      end else if (finish_armed_ff) begin
         event_in = chd_pkg::EV_BUSY;
      end else if (!enable_ff) begin
         event_in = chd_pkg::EV_DISABLED;
      end else if (src_ff == '0) begin
         event_in = chd_pkg::EV_NONE;
      end else if ((src_ff != serving_ff) && ($signed(lvl_ext) < $signed(min_ext))) begin
         event_in = chd_pkg::EV_WEAK;
      end else if ($signed(lvl_ext) > $signed(bar_ext)) begin
         cand_lvl_in = level_ff;
         div_needed  = 1'b1;
         if (src_ff == serving_ff) begin
            cand_id_in     = serving_ff;
            start_armed_in = 1'b0;
            start_count_in = '0;
            event_in       = chd_pkg::EV_SERVING_STRONGER;
         end else begin
            cand_id_in = src_ff;
            if (!start_armed_ff) begin
               start_armed_in = 1'b1;
               start_count_in = start_delay_ff;
            end
            event_in = chd_pkg::EV_NEW_CANDIDATE;
         end
      end else if (src_ff != serving_ff) begin
         event_in = chd_pkg::EV_NONE;
      end else if ($signed(lvl_ext) >= $signed(min_ext)) begin
         cand_lvl_in = level_ff;
         div_needed  = 1'b1;
         event_in    = chd_pkg::EV_SERVING_REFRESH;
      end else if (cand_id_ff == serving_ff) begin
         cand_id_in  = '0;
         cand_lvl_in = chd_pkg::VERY_BAD_LEVEL;
         thr_clear   = 1'b1;
         if (!start_armed_ff) begin
            start_armed_in = 1'b1;
            start_count_in = start_delay_ff;
         end
         event_in = chd_pkg::EV_SERVING_LOST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serving_ff      <= '0;
         cand_id_ff      <= '0;
         cand_lvl_ff     <= chd_pkg::VERY_BAD_LEVEL;
         thr_ff          <= '0;
         start_armed_ff  <= 1'b0;
         start_count_ff  <= '0;
         finish_armed_ff <= 1'b0;
         finish_count_ff <= '0;
         event_ff        <= chd_pkg::EV_NONE;
      end else begin
         if (cmd.exec) begin
            serving_ff      <= serving_in;
            cand_id_ff      <= cand_id_in;
            cand_lvl_ff     <= cand_lvl_in;
            start_armed_ff  <= start_armed_in;
            start_count_ff  <= start_count_in;
            finish_armed_ff <= finish_armed_in;
            finish_count_ff <= finish_count_in;
            event_ff        <= event_in;
         end
         if (cmd.exec && thr_clear) begin
            thr_ff <= '0;
         end else if (div_done) begin
            thr_ff <= div_quotient;
         end
      end
   end

   chd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && div_needed),
      .dividend (div_dividend),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_event_ff    <= event_ff;
         rsp_serving_ff  <= serving_ff;
         rsp_cand_id_ff  <= cand_id_ff;
         rsp_cand_lvl_ff <= cand_lvl_ff;
         rsp_busy_ff     <= finish_armed_ff;
      end
   end

   assign status.div_needed = div_needed;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_code      = rsp_event_ff;
   assign rsp_serving_cell    = rsp_serving_ff;
   assign rsp_candidate_cell  = rsp_cand_id_ff;
   assign rsp_candidate_level = rsp_cand_lvl_ff;
   assign rsp_handover_busy   = rsp_busy_ff;

endmodule

[rtl/chd_controller.sv]
// Controller state machine that sequences capture, decision, threshold division and result.
module chd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  chd_pkg::status_type  status,
   output chd_pkg::cmd_type     cmd
);

   chd_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         chd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = chd_pkg::ST_EXEC;
            end
         end
         chd_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.div_needed ? chd_pkg::ST_DIV_WAIT : chd_pkg::ST_OUT;
         end
         chd_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = chd_pkg::ST_OUT;
            end
         end
         chd_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = chd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/cell_handover_decider.sv]
// Top level of the cell handover decider with hysteresis.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    req_type, req_source_cell, req_level
//   rsp_      out         rsp_valid/rsp_ready    event code, cells, candidate level, busy
//   csr_      in          csr_valid/csr_ready    csr_index, csr_wdata
//
// A request that leaves the threshold unchanged passes from IDLE through EXEC to OUT, where
// its result is loaded; a request that recomputes the threshold also waits in DIV_WAIT for
// the bit-serial threshold divider.
// One request is in work at a time; the next is accepted while a result waits in the
// output register.
// Reset is synchronous and restores the detached state and the register defaults.
// A stalled result holds the controller in its OUT state until the output register frees.
module cell_handover_decider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  chd_pkg::cell_id_type                  req_source_cell,
   input  chd_pkg::level_type                    req_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [chd_pkg::EVENT_BITS-1:0]        rsp_event_code,
   output chd_pkg::cell_id_type                  rsp_serving_cell,
   output chd_pkg::cell_id_type                  rsp_candidate_cell,
   output chd_pkg::level_type                    rsp_candidate_level,
   output logic                                  rsp_handover_busy,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [chd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [chd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   chd_pkg::cmd_type    cmd;
   chd_pkg::status_type status;

   assign csr_ready = 1'b1;

   chd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   chd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_type            (req_type),
      .req_source_cell     (req_source_cell),
      .req_level           (req_level),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_code      (rsp_event_code),
      .rsp_serving_cell    (rsp_serving_cell),
      .rsp_candidate_cell  (rsp_candidate_cell),
      .rsp_candidate_level (rsp_candidate_level),
      .rsp_handover_busy   (rsp_handover_busy)
   );

`ifndef NO_ASSERTIONS
   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.exec && !req_ready))
      else $error("Accepted request was not executed in the following cycle.");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("Result loaded while the previous result was still waiting.");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_valid && req_ready))
      else $error("Loaded result is not presented or controller did not return to idle.");
`endif

endmodule
